// ===== rtl/sce_pkg.sv =====
`default_nettype none

package sce_pkg;

  // sizes
  localparam int VOCAB    = 1024;
  localparam int MAX_ROWS = 4096;
  localparam int IDX_W    = $clog2(VOCAB);
  localparam int CNT_W    = $clog2(VOCAB + 1);
  localparam int SUM_W    = IDX_W + 17;
  localparam int E_W      = $clog2(SUM_W - 16);
  localparam int ROW_W    = $clog2(MAX_ROWS + 1);
  localparam int LOSS_W   = 13;
  localparam int ACC_W    = 16;
  localparam int LSUM_W   = $clog2(MAX_ROWS) + LOSS_W;

  // fixed point constants
  localparam logic [32:0]       LOG2E_Q32 = 33'd6196328019;
  localparam logic [31:0]       LN2_Q32   = 32'd2977044472;
  localparam logic [LOSS_W-1:0] LOSS_CAP  = 13'd7073;

  // datapath operations
  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_ACCEPT   = 5'd1;
  localparam logic [4:0] OP_RD       = 5'd2;
  localparam logic [4:0] OP_DIFF     = 5'd3;
  localparam logic [4:0] OP_FRAC     = 5'd4;
  localparam logic [4:0] OP_TU       = 5'd5;
  localparam logic [4:0] OP_RECIP    = 5'd6;
  localparam logic [4:0] OP_CORR     = 5'd7;
  localparam logic [4:0] OP_TERM     = 5'd8;
  localparam logic [4:0] OP_NINIT    = 5'd9;
  localparam logic [4:0] OP_NORM     = 5'd10;
  localparam logic [4:0] OP_DIV_LN   = 5'd11;
  localparam logic [4:0] OP_DIV_STEP = 5'd12;
  localparam logic [4:0] OP_Z2       = 5'd13;
  localparam logic [4:0] OP_LQ       = 5'd14;
  localparam logic [4:0] OP_LC       = 5'd15;
  localparam logic [4:0] OP_LP       = 5'd16;
  localparam logic [4:0] OP_LFIN     = 5'd17;
  localparam logic [4:0] OP_LRND     = 5'd18;
  localparam logic [4:0] OP_ACC      = 5'd19;
  localparam logic [4:0] OP_DIV_MEAN = 5'd20;
  localparam logic [4:0] OP_DIV_ACC  = 5'd21;
  localparam logic [4:0] OP_EMIT     = 5'd22;

  typedef struct packed {
    logic signed [15:0] logit_value;
    logic [9:0]         target_index;
    logic               row_end;
    logic               batch_end;
  } in_item_t;

  typedef struct packed {
    logic [LOSS_W-1:0] row_loss;
    logic              row_correct;
    logic              batch_done;
    logic [LOSS_W-1:0] mean_loss;
    logic [ACC_W-1:0]  accuracy;
  } out_item_t;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic last_elem;
    logic k_last;
    logic lk_last;
    logic norm_done;
    logic div_last;
    logic bend;
  } status_t;

  // floor(2^36 / k) for the series divisors
  function automatic logic [35:0] recip36(input logic [4:0] k);
    logic [35:0] r;
    case (k)
      5'd2:    r = 36'd34359738368;
      5'd3:    r = 36'd22906492245;
      5'd4:    r = 36'd17179869184;
      5'd5:    r = 36'd13743895347;
      5'd6:    r = 36'd11453246122;
      5'd7:    r = 36'd9817068105;
      5'd8:    r = 36'd8589934592;
      5'd9:    r = 36'd7635497415;
      5'd10:   r = 36'd6871947673;
      5'd11:   r = 36'd6247225157;
      5'd12:   r = 36'd5726623061;
      5'd13:   r = 36'd5286113595;
      5'd15:   r = 36'd4581298449;
      5'd17:   r = 36'd4042322160;
      5'd19:   r = 36'd3616814565;
      5'd21:   r = 36'd3272356035;
      default: r = 36'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sce_in_if.sv =====
`default_nettype none

interface sce_in_if;
  logic               valid;
  logic               ready;
  sce_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sce_out_if.sv =====
`default_nettype none

interface sce_out_if;
  logic               valid;
  logic               ready;
  sce_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sce_dp.sv =====
`default_nettype none

module sce_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sce_pkg::cmd_t       cmd,
  input  wire sce_pkg::in_item_t   in_item,
  output sce_pkg::status_t         status,
  output sce_pkg::out_item_t       out_item
);

  // row storage
  logic [15:0] row_mem [sce_pkg::VOCAB];
  logic signed [15:0] rd_data;

  // row state
  logic [sce_pkg::CNT_W-1:0] count;
  logic signed [15:0]        mx;
  logic signed [15:0]        xt;
  logic [sce_pkg::IDX_W-1:0] best;
  logic [sce_pkg::IDX_W-1:0] target;
  logic [sce_pkg::IDX_W-1:0] idx;
  logic                      bend;

  // exp unit
  logic [8:0]               ip;
  logic [31:0]              f;
  logic [31:0]              u;
  logic [32:0]              t;
  logic [31:0]              v;
  logic [31:0]              q0;
  logic signed [34:0]       s;
  logic [4:0]               k;
  logic [sce_pkg::SUM_W-1:0] sum;

  // log unit and divider
  logic [sce_pkg::SUM_W-1:0] sn;
  logic [sce_pkg::E_W-1:0]   e;
  logic [33:0]               rem;
  logic [33:0]               dd;
  logic [31:0]               quo;
  logic [4:0]                dcnt;
  logic [31:0]               z2;
  logic [31:0]               pw;
  logic [32:0]               acc;
  logic [40:0]               lval;
  logic [sce_pkg::LOSS_W-1:0] loss;
  logic                      correct;
  logic [sce_pkg::LOSS_W-1:0] mean;

  // batch state
  logic [sce_pkg::LSUM_W-1:0] lsum;
  logic [sce_pkg::ROW_W-1:0]  ccnt;
  logic [sce_pkg::ROW_W-1:0]  rcnt;

  // combinational terms
  logic                      count_lt;
  logic signed [16:0]        diff;
  logic [48:0]               dprod;
  logic [63:0]               uprod;
  logic [64:0]               tprod;
  logic [31:0]               rop;
  logic [67:0]               rprod;
  logic [31:0]               cop;
  logic [31:0]               rdiff;
  logic [31:0]               qfix;
  logic [33:0]               sc;
  logic [5:0]                sh;
  logic [35:0]               rnd;
  logic [35:0]               rsh;
  logic [16:0]               term;
  logic [32:0]               m;
  logic [34:0]               dtmp;
  logic                      dge;
  logic [63:0]               zprod;
  logic [63:0]               pprod;
  logic [15:0]               dlt;
  logic [40:0]               lr;
  logic                      in_row;

  assign count_lt = count < sce_pkg::CNT_W'(sce_pkg::VOCAB);
  assign diff     = {mx[15], mx} - {rd_data[15], rd_data};
  assign dprod    = 49'(diff[15:0]) * 49'(sce_pkg::LOG2E_Q32);
  assign uprod    = 64'(f) * 64'(sce_pkg::LN2_Q32);
  assign tprod    = 65'(t) * 65'(u);
  assign rop      = (cmd.op == sce_pkg::OP_LQ) ? pw : v;
  assign rprod    = 68'(rop) * 68'(sce_pkg::recip36(k));
  assign zprod    = 64'(quo) * 64'(quo);
  assign pprod    = 64'(pw) * 64'(z2);
  assign m        = 33'(sn) << (33 - sce_pkg::SUM_W);
  assign dlt      = 16'(mx - xt);
  assign lr       = (lval + (41'd1 << 23)) >> 24;
  assign in_row   = sce_pkg::CNT_W'(target) < count;

  // exact divide by a small constant: reciprocal estimate plus one correction
  always_comb begin
    cop   = (cmd.op == sce_pkg::OP_LC) ? pw : v;
    rdiff = cop - (q0 * 32'(k));
    if (k == 5'd1) begin
      qfix = cop;
    end else begin
      qfix = q0 + ((rdiff >= 32'(k)) ? 32'd1 : 32'd0);
    end
  end

  // rounded shift of the series value down to q1.16
  always_comb begin
    sc   = s[34] ? 34'd0 : s[33:0];
    sh   = 6'(ip[4:0]) + 6'd16;
    rnd  = 36'd0;
    rsh  = 36'd0;
    term = 17'd0;
    if (ip <= 9'd18) begin
      rnd  = {2'b00, sc} + (36'd1 << (sh - 6'd1));
      rsh  = rnd >> sh;
      term = rsh[16:0];
    end
  end

  // restoring divider step
  assign dtmp = {rem, quo[31]};
  assign dge  = dtmp >= {1'b0, dd};

  // status to the controller
  always_comb begin
    status.last_elem = sce_pkg::CNT_W'(idx) == (count - sce_pkg::CNT_W'(1));
    status.k_last    = k == 5'd12;
    status.lk_last   = k == 5'd21;
    status.norm_done = sn[sce_pkg::SUM_W-1];
    status.div_last  = dcnt == 5'd31;
    status.bend      = bend;
  end

  // memory write on load, registered read in the exp pass
  always_ff @(posedge clk) begin
    if (cmd.op == sce_pkg::OP_ACCEPT && count_lt) begin
      row_mem[count[sce_pkg::IDX_W-1:0]] <= in_item.logit_value;
    end
    if (cmd.op == sce_pkg::OP_RD) begin
      rd_data <= row_mem[idx];
    end
  end

  // control counters and batch accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rcnt  <= '0;
      lsum  <= '0;
      ccnt  <= '0;
    end else begin
      case (cmd.op)
        sce_pkg::OP_ACCEPT: begin
          if (count_lt) count <= count + sce_pkg::CNT_W'(1);
        end
        sce_pkg::OP_ACC: begin
          if (rcnt < sce_pkg::ROW_W'(sce_pkg::MAX_ROWS)) begin
            rcnt <= rcnt + sce_pkg::ROW_W'(1);
            lsum <= lsum + sce_pkg::LSUM_W'(loss);
            ccnt <= ccnt + sce_pkg::ROW_W'(correct);
          end
        end
        sce_pkg::OP_EMIT: begin
          count <= '0;
          if (bend) begin
            rcnt <= '0;
            lsum <= '0;
            ccnt <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      sce_pkg::OP_ACCEPT: begin
        if (count_lt) begin
          if (count == '0) begin
            mx   <= in_item.logit_value;
            best <= '0;
          end else if (in_item.logit_value > mx) begin
            mx   <= in_item.logit_value;
            best <= count[sce_pkg::IDX_W-1:0];
          end
        end
        target <= in_item.target_index[sce_pkg::IDX_W-1:0];
        bend   <= in_item.row_end & in_item.batch_end;
        idx    <= '0;
        sum    <= '0;
      end
      sce_pkg::OP_DIFF: begin
        ip <= dprod[48:40];
        f  <= dprod[39:8];
        if (idx == target) xt <= rd_data;
      end
      sce_pkg::OP_FRAC: begin
        u <= uprod[63:32];
        t <= 33'h1_0000_0000;
        s <= 35'sh1_0000_0000;
        k <= 5'd1;
      end
      sce_pkg::OP_TU: begin
        v <= tprod[63:32];
      end
      sce_pkg::OP_RECIP, sce_pkg::OP_LQ: begin
        q0 <= rprod[67:36];
      end
      sce_pkg::OP_CORR: begin
        t <= 33'(qfix);
        if (k[0]) s <= s - $signed({3'b000, qfix});
        else      s <= s + $signed({3'b000, qfix});
        k <= k + 5'd1;
      end
      sce_pkg::OP_TERM: begin
        sum <= sum + sce_pkg::SUM_W'(term);
        idx <= idx + sce_pkg::IDX_W'(1);
      end
      sce_pkg::OP_NINIT: begin
        sn <= (sum < sce_pkg::SUM_W'(65536)) ? sce_pkg::SUM_W'(65536) : sum;
        e  <= sce_pkg::E_W'(sce_pkg::SUM_W - 17);
      end
      sce_pkg::OP_NORM: begin
        if (!sn[sce_pkg::SUM_W-1]) begin
          sn <= sn << 1;
          e  <= e - sce_pkg::E_W'(1);
        end
      end
      sce_pkg::OP_DIV_LN: begin
        rem  <= {2'b00, m[31:0]};
        dd   <= {2'b10, m[31:0]};
        quo  <= '0;
        dcnt <= '0;
      end
      sce_pkg::OP_DIV_STEP: begin
        if (dge) begin
          rem <= 34'(dtmp - {1'b0, dd});
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= dtmp[33:0];
          quo <= {quo[30:0], 1'b0};
        end
        dcnt <= dcnt + 5'd1;
      end
      sce_pkg::OP_Z2: begin
        z2  <= zprod[63:32];
        pw  <= quo;
        acc <= '0;
        k   <= 5'd1;
      end
      sce_pkg::OP_LC: begin
        acc <= acc + 33'(qfix);
      end
      sce_pkg::OP_LP: begin
        pw <= pprod[63:32];
        k  <= k + 5'd2;
      end
      sce_pkg::OP_LFIN: begin
        lval <= 41'({acc, 1'b0}) + 41'(36'(e) * 36'(sce_pkg::LN2_Q32))
              + (41'(dlt) << 24);
      end
      sce_pkg::OP_LRND: begin
        if (!in_row) begin
          loss <= sce_pkg::LOSS_CAP;
        end else if (lr > 41'(sce_pkg::LOSS_CAP)) begin
          loss <= sce_pkg::LOSS_CAP;
        end else begin
          loss <= lr[sce_pkg::LOSS_W-1:0];
        end
        correct <= in_row && (best == target);
      end
      sce_pkg::OP_DIV_MEAN: begin
        rem  <= '0;
        dd   <= 34'(rcnt);
        quo  <= 32'(lsum) + 32'(rcnt >> 1);
        dcnt <= '0;
      end
      sce_pkg::OP_DIV_ACC: begin
        mean <= quo[sce_pkg::LOSS_W-1:0];
        rem  <= '0;
        quo  <= (32'(ccnt) << 15) + 32'(rcnt >> 1);
        dcnt <= '0;
      end
      sce_pkg::OP_EMIT: begin
        out_item.row_loss    <= loss;
        out_item.row_correct <= correct;
        out_item.batch_done  <= bend;
        out_item.mean_loss   <= bend ? mean : '0;
        out_item.accuracy    <= bend ? quo[sce_pkg::ACC_W-1:0] : '0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sce_ctrl.sv =====
`default_nettype none

module sce_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_row_end,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire sce_pkg::status_t  status,
  output sce_pkg::cmd_t          cmd
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_RD    = 5'd1;
  localparam logic [4:0] ST_DIFF  = 5'd2;
  localparam logic [4:0] ST_FRAC  = 5'd3;
  localparam logic [4:0] ST_TU    = 5'd4;
  localparam logic [4:0] ST_RECIP = 5'd5;
  localparam logic [4:0] ST_CORR  = 5'd6;
  localparam logic [4:0] ST_TERM  = 5'd7;
  localparam logic [4:0] ST_NINIT = 5'd8;
  localparam logic [4:0] ST_NORM  = 5'd9;
  localparam logic [4:0] ST_DINIT = 5'd10;
  localparam logic [4:0] ST_DIVL  = 5'd11;
  localparam logic [4:0] ST_Z2    = 5'd12;
  localparam logic [4:0] ST_LQ    = 5'd13;
  localparam logic [4:0] ST_LC    = 5'd14;
  localparam logic [4:0] ST_LP    = 5'd15;
  localparam logic [4:0] ST_LFIN  = 5'd16;
  localparam logic [4:0] ST_LRND  = 5'd17;
  localparam logic [4:0] ST_ACC   = 5'd18;
  localparam logic [4:0] ST_DMI   = 5'd19;
  localparam logic [4:0] ST_DIVM  = 5'd20;
  localparam logic [4:0] ST_DAI   = 5'd21;
  localparam logic [4:0] ST_DIVA  = 5'd22;
  localparam logic [4:0] ST_EMIT  = 5'd23;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       out_valid_next;

  assign in_ready = state == ST_IDLE;

  // sequencing of the row and batch passes
  always_comb begin
    state_next     = state;
    cmd.op         = sce_pkg::OP_NONE;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = sce_pkg::OP_ACCEPT;
          if (in_row_end) state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.op     = sce_pkg::OP_RD;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.op     = sce_pkg::OP_DIFF;
        state_next = ST_FRAC;
      end
      ST_FRAC: begin
        cmd.op     = sce_pkg::OP_FRAC;
        state_next = ST_TU;
      end
      ST_TU: begin
        cmd.op     = sce_pkg::OP_TU;
        state_next = ST_RECIP;
      end
      ST_RECIP: begin
        cmd.op     = sce_pkg::OP_RECIP;
        state_next = ST_CORR;
      end
      ST_CORR: begin
        cmd.op     = sce_pkg::OP_CORR;
        state_next = status.k_last ? ST_TERM : ST_TU;
      end
      ST_TERM: begin
        cmd.op     = sce_pkg::OP_TERM;
        state_next = status.last_elem ? ST_NINIT : ST_RD;
      end
      ST_NINIT: begin
        cmd.op     = sce_pkg::OP_NINIT;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        if (status.norm_done) state_next = ST_DINIT;
        else                  cmd.op     = sce_pkg::OP_NORM;
      end
      ST_DINIT: begin
        cmd.op     = sce_pkg::OP_DIV_LN;
        state_next = ST_DIVL;
      end
      ST_DIVL: begin
        cmd.op = sce_pkg::OP_DIV_STEP;
        if (status.div_last) state_next = ST_Z2;
      end
      ST_Z2: begin
        cmd.op     = sce_pkg::OP_Z2;
        state_next = ST_LQ;
      end
      ST_LQ: begin
        cmd.op     = sce_pkg::OP_LQ;
        state_next = ST_LC;
      end
      ST_LC: begin
        cmd.op     = sce_pkg::OP_LC;
        state_next = status.lk_last ? ST_LFIN : ST_LP;
      end
      ST_LP: begin
        cmd.op     = sce_pkg::OP_LP;
        state_next = ST_LQ;
      end
      ST_LFIN: begin
        cmd.op     = sce_pkg::OP_LFIN;
        state_next = ST_LRND;
      end
      ST_LRND: begin
        cmd.op     = sce_pkg::OP_LRND;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.op     = sce_pkg::OP_ACC;
        state_next = status.bend ? ST_DMI : ST_EMIT;
      end
      ST_DMI: begin
        cmd.op     = sce_pkg::OP_DIV_MEAN;
        state_next = ST_DIVM;
      end
      ST_DIVM: begin
        cmd.op = sce_pkg::OP_DIV_STEP;
        if (status.div_last) state_next = ST_DAI;
      end
      ST_DAI: begin
        cmd.op     = sce_pkg::OP_DIV_ACC;
        state_next = ST_DIVA;
      end
      ST_DIVA: begin
        cmd.op = sce_pkg::OP_DIV_STEP;
        if (status.div_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.op         = sce_pkg::OP_EMIT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/softmax_cross_entropy_loss_unit.sv =====
// channel   dir   payload                                               beat
// items     in    logit_value, target_index, row_end, batch_end         one logit
// results   out   row_loss, row_correct, batch_done, mean_loss, accuracy one row
//
// a logit that does not end a row is taken and leaves the block ready for the next
// a row of n logits then runs through the exp unit (a series of twelve terms
// after the leading one, each a multiply, reciprocal and correction step), then
// through the log unit and divider, and then the result is emitted
// a row that ends a batch also runs the two batch divisions
// rst is synchronous; it clears the counts and batch accumulators
// a stalled result sits in the output register while the next row loads
`default_nettype none

module softmax_cross_entropy_loss_unit (
  input wire logic    clk,
  input wire logic    rst,
  sce_in_if.sink      items,
  sce_out_if.source   results
);

  sce_pkg::cmd_t    cmd;
  sce_pkg::status_t status;

  // sequencer
  sce_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (items.valid),
    .in_row_end (items.data.row_end),
    .in_ready   (items.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // storage and arithmetic
  sce_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (items.data),
    .status   (status),
    .out_item (results.data)
  );

endmodule

`default_nettype wire

// ===== rtl/sce_checker.sv =====
`default_nettype none

module sce_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_row_end,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire sce_pkg::out_item_t out_item
);

  // a result beat stays offered until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before taken");

  // a logit inside a row leaves the block ready for the next
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_row_end |=> in_ready)
    else $error("stall after a mid-row logit");

  // a row end starts the row pass
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_row_end |=> !in_ready)
    else $error("row end did not start the row pass");

  // losses stay under the cap and batch fields are zero off batch end
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.row_loss <= sce_pkg::LOSS_CAP
      && out_item.mean_loss <= sce_pkg::LOSS_CAP
      && (out_item.batch_done || (out_item.mean_loss == '0 && out_item.accuracy == '0)))
    else $error("result fields out of range");

endmodule

bind softmax_cross_entropy_loss_unit sce_checker u_sce_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (items.valid),
  .in_ready   (items.ready),
  .in_row_end (items.data.row_end),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_item   (results.data)
);

`default_nettype wire
